// ===== rtl/dfnv_pkg.sv =====
`timescale 1ns / 1ps

package dfnv_pkg;

   localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_PRIME   = 64'h00000100000001b3;
   localparam logic [63:0] SEED_FIRST  = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] SEED_SECOND = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] INIT_FIRST  = FNV_BASIS ^ SEED_FIRST;
   localparam logic [63:0] INIT_SECOND = FNV_BASIS ^ SEED_SECOND;

   localparam int unsigned WORD_BYTES = 8;
   localparam int unsigned LEFT_W     = $clog2(WORD_BYTES);

   // Command codes; code 3 carries no meaning and is dropped at the front.
   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_BYTE   = 2'd1,
      CMD_FINISH = 2'd2
   } cmd_type;

   // One queued job: the operation and the bytes to absorb, first byte on top.
   typedef struct packed {
      cmd_type     op;
      logic [63:0] data;
   } job_type;

   // One FNV-1a step: xor the byte in, multiply by the prime mod 2^64.
   // The prime is 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1, so the multiply
   // is a sum of shifted copies.
   function automatic logic [63:0] fnv_absorb(input logic [63:0] h,
                                              input logic [7:0]  b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

// ===== rtl/dfnv_front.sv =====
`timescale 1ns / 1ps

module dfnv_front #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_command,
   input  logic [63:0]       req_user_id,
   input  logic [7:0]        req_type_byte,
   input  logic [63:0]       req_seq_num,
   output logic              job_valid,
   output dfnv_pkg::job_type job,
   input  logic              job_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   dfnv_pkg::job_type queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   dfnv_pkg::job_type new_job;
   logic              keep;
   logic              accept;
   logic              push;
   logic              pop;

   // Classify: drop the unused code, pack the bytes to absorb top first.
   always_comb begin
      keep        = 1'b1;
      new_job.op  = dfnv_pkg::CMD_START;
      new_job.data = req_user_id;
      unique case (req_command)
         dfnv_pkg::CMD_START: begin
            new_job.op   = dfnv_pkg::CMD_START;
            new_job.data = req_user_id;
         end
         dfnv_pkg::CMD_BYTE: begin
            new_job.op   = dfnv_pkg::CMD_BYTE;
            new_job.data = {req_type_byte, 56'd0};
         end
         dfnv_pkg::CMD_FINISH: begin
            new_job.op   = dfnv_pkg::CMD_FINISH;
            new_job.data = req_seq_num;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == FULL_CNT);
   assign accept    = req_valid && !req_stall;
   assign push      = accept && keep;
   assign job_valid = (count_ff != '0);
   assign pop       = job_pop && job_valid;
   assign job       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue fill count out of range");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill count did not grow on push");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < FULL_CNT)
      else $error("push into a full queue");
`endif

endmodule

// ===== rtl/dfnv_back.sv =====
`timescale 1ns / 1ps

module dfnv_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  dfnv_pkg::job_type job,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [63:0]       rsp_sig_hi,
   output logic [63:0]       rsp_sig_lo
);

   logic                          busy_ff, busy_in;
   dfnv_pkg::cmd_type             op_ff, op_in;
   logic [63:0]                   data_ff, data_in;
   logic [dfnv_pkg::LEFT_W-1:0]   left_ff, left_in;
   logic                          first_ff, first_in;
   logic [63:0]                   hash_a_ff, hash_a_in;
   logic [63:0]                   hash_b_ff, hash_b_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [63:0]                   sig_hi_ff, sig_hi_in;
   logic [63:0]                   sig_lo_ff, sig_lo_in;

   logic        last;
   logic        is_finish;
   logic        out_free;
   logic        advance;
   logic        reseed;
   logic [63:0] src_a, src_b;
   logic [63:0] next_a, next_b;

   assign last      = (left_ff == '0);
   assign is_finish = (op_ff == dfnv_pkg::CMD_FINISH);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // Hold the final finish byte until the result register can take it.
   assign advance   = busy_ff && !(last && is_finish && !out_free);
   assign job_pop   = job_valid && (!busy_ff || (advance && last));

   assign reseed = (op_ff == dfnv_pkg::CMD_START) && first_ff;
   assign src_a  = reseed ? dfnv_pkg::INIT_FIRST  : hash_a_ff;
   assign src_b  = reseed ? dfnv_pkg::INIT_SECOND : hash_b_ff;
   assign next_a = dfnv_pkg::fnv_absorb(src_a, data_ff[63:56]);
   assign next_b = dfnv_pkg::fnv_absorb(src_b, data_ff[63:56]);

   always_comb begin
      busy_in      = busy_ff;
      op_in        = op_ff;
      data_in      = data_ff;
      left_in      = left_ff;
      first_in     = first_ff;
      hash_a_in    = hash_a_ff;
      hash_b_in    = hash_b_ff;
      rsp_valid_in = rsp_valid_ff;
      sig_hi_in    = sig_hi_ff;
      sig_lo_in    = sig_lo_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         hash_a_in = next_a;
         hash_b_in = next_b;
         data_in   = {data_ff[55:0], 8'd0};
         left_in   = left_ff - 1'b1;
         first_in  = 1'b0;
         if (last) begin
            busy_in = 1'b0;
            left_in = '0;
            if (is_finish) begin
               rsp_valid_in = 1'b1;
               sig_hi_in    = next_a;
               sig_lo_in    = next_b;
            end
         end
      end

      if (job_pop) begin
         busy_in  = 1'b1;
         op_in    = job.op;
         data_in  = job.data;
         first_in = 1'b1;
         left_in  = (job.op == dfnv_pkg::CMD_BYTE) ? '0
                  : dfnv_pkg::LEFT_W'(dfnv_pkg::WORD_BYTES - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         op_ff        <= dfnv_pkg::CMD_BYTE;
         left_ff      <= '0;
         first_ff     <= 1'b0;
         hash_a_ff    <= dfnv_pkg::INIT_FIRST;
         hash_b_ff    <= dfnv_pkg::INIT_SECOND;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         op_ff        <= op_in;
         left_ff      <= left_in;
         first_ff     <= first_in;
         hash_a_ff    <= hash_a_in;
         hash_b_ff    <= hash_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      sig_hi_ff <= sig_hi_in;
      sig_lo_ff <= sig_lo_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sig_hi = sig_hi_ff;
   assign rsp_sig_lo = sig_lo_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff && is_finish && last))
      else $error("result raised without a finishing step");

   a_left_needs_busy: assert property (@(posedge clock) disable iff (reset)
      left_ff != '0 |-> busy_ff)
      else $error("byte count pending while engine idle");

   a_byte_single: assert property (@(posedge clock) disable iff (reset)
      busy_ff && op_ff == dfnv_pkg::CMD_BYTE |-> last)
      else $error("byte job scheduled for more than one step");
`endif

endmodule

// ===== rtl/dual_fnv1a_signature.sv =====
`timescale 1ns / 1ps
// A finish transfer passes through the front queue and the engine; its signature then sits
//   in the result register, with rsp_valid high, until it is taken.
// Start and finish absorb eight bytes each, a byte item one. The engine absorbs one byte
//   per cycle unless a finish waits on the result register; each hash has its own multiply.
// The front queue holds QUEUE_DEPTH jobs; req_stall rises only while it is full.
// Reset (synchronous): empty queue, idle engine, no result pending, hashes at basis xor seed.

module dual_fnv1a_signature #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_user_id,
   input  logic [7:0]  req_type_byte,
   input  logic [63:0] req_seq_num,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_sig_hi,
   output logic [63:0] rsp_sig_lo
);

   // Jobs classified by the front, waiting for the hash engine.
   logic              job_valid;
   dfnv_pkg::job_type job;
   logic              job_pop;

   // Front: accept each transfer, drop the unused command code, and queue
   // the operation together with the eight (or one) bytes it absorbs.
   dfnv_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_user_id   (req_user_id),
      .req_type_byte (req_type_byte),
      .req_seq_num   (req_seq_num),
      .job_valid     (job_valid),
      .job           (job),
      .job_pop       (job_pop)
   );

   // Back: absorb one byte per cycle into both hashes; a start reseeds on
   // its first byte, a finish loads the result register on its last byte.
   // The result register decouples rsp_stall from the engine except when a
   // second finish is ready before the first is taken.
   dfnv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job        (job),
      .job_pop    (job_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sig_hi (rsp_sig_hi),
      .rsp_sig_lo (rsp_sig_lo)
   );

endmodule
